// ===== design/multi_task_watchdog_table_unit_macros.svh =====
// Assertion macros used by the watchdog table checker.
`ifndef MULTI_TASK_WATCHDOG_TABLE_UNIT_MACROS_SVH
`define MULTI_TASK_WATCHDOG_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MTWDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MTWDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtwdt_pkg.sv =====
// Package with the transaction types and operation codes of the watchdog table.
`timescale 1ns / 1ps
package mtwdt_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_KICK   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CHECK  = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  task_key;
    logic [31:0] holdoff_ticks;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] expired_key;
    logic       is_alarmed;
    logic       table_full;
  } out_t;

endpackage

// ===== design/multi_task_watchdog_table_unit.sv =====
// Multi-task watchdog table: one input transaction gives exactly one result
// transaction. Tick and unused op codes go straight from acceptance to the
// FINISH state and the output register. Kick, remove, query and check walk
// the task table through one memory read port, one slot per cycle, with one
// shared key compare and one elapsed-time subtract-and-compare, stopping at
// the first hit (an expired slot for check) or after the last slot.
// The block takes one transaction at a time: in_ready is high only between
// transactions, while a finished result may still wait in the output register.
`timescale 1ns / 1ps
module multi_task_watchdog_table_unit #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mtwdt_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mtwdt_pkg::out_t  out_data
);
  import mtwdt_pkg::*;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);
  localparam logic [CNT_BITS-1:0] SLOT_COUNT = CNT_BITS'(ENTRIES);

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] holdoff;
    logic                 alarmed;
  } rec_t;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t               state;
  logic [2:0]           op;
  logic [KEY_BITS-1:0]  key;
  logic [TIME_BITS-1:0] hold;
  logic [TIME_BITS-1:0] now_count;
  logic [ENTRIES-1:0]   entry_valid;
  logic [CNT_BITS-1:0]  rd_addr;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_live;
  rec_t                 rd_data;
  logic [IDX_BITS-1:0]  free_slot;
  logic                 free_seen;
  out_t                 res;

  rec_t                 mem [ENTRIES];

  logic                 done;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  mem_waddr;
  rec_t                 mem_wdata;
  logic                 valid_set;
  logic                 valid_clr;
  out_t                 res_next;
  logic                 slot_valid;
  logic                 hit;
  logic                 expire;
  logic                 last_eval;
  logic                 free_here;
  logic [TIME_BITS-1:0] gone;

  assign in_ready = (state == IDLE);

  // Shared evaluation of the slot whose record was read last cycle.
  always_comb begin
    slot_valid = rd_live && entry_valid[rd_idx];
    hit        = slot_valid && (rd_data.key == key);
    gone       = now_count - rd_data.last;
    expire     = slot_valid && !rd_data.alarmed && (gone >= rd_data.holdoff);
    last_eval  = rd_live && (rd_idx == LAST_IDX);
    free_here  = rd_live && !entry_valid[rd_idx] && !free_seen;

    done       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx;
    mem_wdata  = '{key: key, last: now_count, holdoff: hold, alarmed: 1'b0};
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    res_next   = res;

    if (state == SCAN) begin
      case (op)
        OP_KICK: begin
          if (hit) begin
            mem_we = 1'b1;
            done   = 1'b1;
          end else if (last_eval) begin
            done = 1'b1;
            if (free_seen || free_here) begin
              mem_we    = 1'b1;
              valid_set = 1'b1;
              mem_waddr = free_seen ? free_slot : rd_idx;
            end else begin
              res_next.table_full = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            valid_clr = 1'b1;
            done      = 1'b1;
          end else if (last_eval) begin
            done = 1'b1;
          end
        end
        OP_QUERY: begin
          if (hit) begin
            res_next.is_alarmed = rd_data.alarmed;
            done                = 1'b1;
          end else if (last_eval) begin
            done = 1'b1;
          end
        end
        OP_CHECK: begin
          if (expire) begin
            mem_we               = 1'b1;
            mem_wdata            = rd_data;
            mem_wdata.alarmed    = 1'b1;
            res_next.found       = 1'b1;
            res_next.expired_key = 8'(rd_data.key);
            done                 = 1'b1;
          end else if (last_eval) begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr[IDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      now_count   <= '0;
      entry_valid <= '0;
      rd_live     <= 1'b0;
      free_seen   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            op        <= in_data.op;
            key       <= KEY_BITS'(in_data.task_key);
            hold      <= TIME_BITS'(in_data.holdoff_ticks);
            rd_addr   <= '0;
            rd_live   <= 1'b0;
            free_seen <= 1'b0;
            res       <= '0;
            case (in_data.op) inside
              OP_TICK: begin
                now_count <= now_count + 1'b1;
                state     <= FINISH;
              end
              OP_KICK, OP_REMOVE, OP_CHECK, OP_QUERY: begin
                state <= SCAN;
              end
              default: begin
                state <= FINISH;
              end
            endcase
          end
        end
        SCAN: begin
          rd_idx  <= rd_addr[IDX_BITS-1:0];
          rd_live <= (rd_addr < SLOT_COUNT) && !done;
          if (rd_addr < SLOT_COUNT) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (free_here) begin
            free_seen <= 1'b1;
            free_slot <= rd_idx;
          end
          if (valid_set) begin
            entry_valid[mem_waddr] <= 1'b1;
          end
          if (valid_clr) begin
            entry_valid[rd_idx] <= 1'b0;
          end
          if (done) begin
            res   <= res_next;
            state <= FINISH;
          end
        end
        FINISH: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/mtwdt_chk.sv =====
// Port-level checker for the watchdog table and its bind to the top level.
`timescale 1ns / 1ps
`include "multi_task_watchdog_table_unit_macros.svh"
module mtwdt_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input mtwdt_pkg::out_t out_data
);
  import mtwdt_pkg::*;

  `MTWDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `MTWDT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a second transaction while busy")
  `MTWDT_ASSERT_NOW(a_one_flag, out_valid, $countones({out_data.found, out_data.is_alarmed, out_data.table_full}) <= 1, "more than one result flag set")
  `MTWDT_ASSERT_NOW(a_key_zero, out_valid && !out_data.found, out_data.expired_key == 8'd0, "expired key without a find")

endmodule

bind multi_task_watchdog_table_unit mtwdt_chk u_mtwdt_chk (.*);
